// ===== rtl/tla_pkg.sv =====
package tla_pkg;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  typedef struct packed {
    logic accept_ok;
    logic step_clr;
    logic clear_wr;
    logic res_clear;
    logic cell_write;
    logic cell_capture;
    logic adv_step;
    logic gen_set;
    logic out_load;
  } tla_ctrl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       item_taken;
    logic       in_grid;
    logic       run_en;
    logic       clear_last;
    logic       adv_last;
    logic       out_free;
  } tla_stat_t;

endpackage

// ===== rtl/tla_req_if.sv =====
interface tla_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] row;
  logic [5:0] col;
  logic       value;

  modport source (output valid, output cmd, output row, output col, output value,
                  input ready);
  modport sink (input valid, input cmd, input row, input col, input value,
                output ready);
endinterface

// ===== rtl/tla_rsp_if.sv =====
interface tla_rsp_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic generation_done;

  modport source (output valid, output cell_value, output generation_done,
                  input ready);
  modport sink (input valid, input cell_value, input generation_done,
                output ready);
endinterface

// ===== rtl/toroidal_life_automaton_unit.sv =====
// An accepted item passes S_DISPATCH, then S_WR_READ and S_WR_WRITE for a write, S_RD_READ and
// S_RD_CAPTURE for a read, S_ADVANCE for an advance; an unused command, an address off the grid
// or a stopped advance goes straight on to S_FINISH. No new item is taken until S_FINISH has
// loaded the result and the FSM is back in S_IDLE. The advance walks the row memory one row
// word per cycle. Reset clears control state, then a clearing pass writes every row dead
// while request.ready stays low; configuration writes are taken throughout.
module toroidal_life_automaton_unit import tla_pkg::*; #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input logic       clk,
  input logic       rst,
  tla_req_if.sink   request,
  tla_rsp_if.source response,
  input logic       cfg_write,
  input logic       cfg_data
);

  tla_ctrl_t ctrl;
  tla_stat_t stat;

  tla_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .ctrl(ctrl)
  );

  tla_datapath #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .ctrl     (ctrl),
    .stat     (stat)
  );

endmodule

// ===== rtl/tla_ram.sv =====
module tla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tla_ctrl.sv =====
module tla_ctrl import tla_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tla_stat_t stat,
  output tla_ctrl_t ctrl
);

  typedef enum logic [8:0] {
    S_CLEAR      = 9'b000000001,
    S_IDLE       = 9'b000000010,
    S_DISPATCH   = 9'b000000100,
    S_WR_READ    = 9'b000001000,
    S_WR_WRITE   = 9'b000010000,
    S_RD_READ    = 9'b000100000,
    S_RD_CAPTURE = 9'b001000000,
    S_ADVANCE    = 9'b010000000,
    S_FINISH     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctrl       = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctrl.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ctrl.accept_ok = 1'b1;
        ctrl.step_clr  = 1'b1;
        if (stat.item_taken) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ctrl.res_clear = 1'b1;
        case (stat.op)
          CMD_WRITE:   state_next = stat.in_grid ? S_WR_READ : S_FINISH;
          CMD_READ:    state_next = stat.in_grid ? S_RD_READ : S_FINISH;
          CMD_ADVANCE: state_next = stat.run_en ? S_ADVANCE : S_FINISH;
          default:     state_next = S_FINISH;
        endcase
      end
      S_WR_READ: begin
        state_next = S_WR_WRITE;
      end
      S_WR_WRITE: begin
        ctrl.cell_write = 1'b1;
        state_next      = S_FINISH;
      end
      S_RD_READ: begin
        state_next = S_RD_CAPTURE;
      end
      S_RD_CAPTURE: begin
        ctrl.cell_capture = 1'b1;
        state_next        = S_FINISH;
      end
      S_ADVANCE: begin
        ctrl.adv_step = 1'b1;
        if (stat.adv_last) begin
          ctrl.gen_set = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/tla_datapath.sv =====
module tla_datapath import tla_pkg::*; #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic       clk,
  input  logic       rst,
  tla_req_if.sink    request,
  tla_rsp_if.source  response,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  tla_ctrl_t  ctrl,
  output tla_stat_t  stat
);

  localparam int AW = $clog2(GRID_ROWS);
  localparam int SW = $clog2(GRID_ROWS + 3);
  localparam int CW = $clog2(GRID_COLS);
  localparam logic [SW-1:0] ADV_LAST   = SW'(GRID_ROWS + 2);
  localparam logic [SW-1:0] CLEAR_LAST = SW'(GRID_ROWS - 1);
  localparam logic [SW-1:0] STEP_FIRST = SW'(2);
  localparam logic [SW-1:0] STEP_WRITE = SW'(3);
  localparam logic [AW-1:0] ROW_TOP    = AW'(GRID_ROWS - 1);

  logic                 run_enable;
  logic [1:0]           cmd_q;
  logic [5:0]           row_q;
  logic [5:0]           col_q;
  logic                 value_q;
  logic [SW-1:0]        step;
  logic [GRID_COLS-1:0] up_row;
  logic [GRID_COLS-1:0] mid_row;
  logic [GRID_COLS-1:0] first_row;
  logic                 res_cell;
  logic                 res_gen;
  logic                 out_valid;
  logic                 out_cell;
  logic                 out_gen;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [GRID_COLS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [GRID_COLS-1:0] ram_rdata;

  logic                 item_taken;
  logic [AW-1:0]        row_addr;
  logic [CW-1:0]        col_idx;
  logic [GRID_COLS-1:0] cell_mask;
  logic [GRID_COLS-1:0] wr_row;
  logic [SW-1:0]        step_m1;
  logic [SW-1:0]        step_m3;
  logic [AW-1:0]        adv_raddr;
  logic [GRID_COLS-1:0] dn_row;
  logic [GRID_COLS-1:0] next_row;
  logic                 in_grid;

  assign request.ready = ctrl.accept_ok;
  assign item_taken    = request.valid && ctrl.accept_ok;

  assign row_addr  = AW'(row_q);
  assign col_idx   = CW'(col_q);
  assign in_grid   = (32'(row_q) < 32'(GRID_ROWS)) && (32'(col_q) < 32'(GRID_COLS));
  assign cell_mask = {{(GRID_COLS - 1){1'b0}}, 1'b1} << col_idx;
  assign wr_row    = value_q ? (ram_rdata | cell_mask) : (ram_rdata & ~cell_mask);
  assign step_m1   = step - SW'(1);
  assign step_m3   = step - STEP_WRITE;
  assign adv_raddr = (step == '0) ? ROW_TOP : step_m1[AW-1:0];
  assign dn_row    = (step == ADV_LAST) ? first_row : ram_rdata;

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    localparam int LF = (c == 0) ? GRID_COLS - 1 : c - 1;
    localparam int RT = (c == GRID_COLS - 1) ? 0 : c + 1;
    logic [3:0] count;
    assign count = 4'(up_row[LF]) + 4'(up_row[c]) + 4'(up_row[RT])
                 + 4'(mid_row[LF]) + 4'(mid_row[RT])
                 + 4'(dn_row[LF]) + 4'(dn_row[c]) + 4'(dn_row[RT]);
    assign next_row[c] = (count == 4'd3) || (mid_row[c] && (count == 4'd2));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = step[AW-1:0];
    ram_wdata = '0;
    ram_raddr = row_addr;
    if (ctrl.clear_wr) begin
      ram_we = 1'b1;
    end
    if (ctrl.cell_write) begin
      ram_we    = 1'b1;
      ram_waddr = row_addr;
      ram_wdata = wr_row;
    end
    if (ctrl.adv_step) begin
      ram_raddr = adv_raddr;
      if (step >= STEP_WRITE) begin
        ram_we    = 1'b1;
        ram_waddr = step_m3[AW-1:0];
        ram_wdata = next_row;
      end
    end
  end

  tla_ram #(
    .WIDTH(GRID_COLS),
    .DEPTH(GRID_ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable <= 1'b0;
      step       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        run_enable <= cfg_data;
      end
      if (ctrl.step_clr) begin
        step <= '0;
      end else if (ctrl.clear_wr || ctrl.adv_step) begin
        step <= step + SW'(1);
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_taken) begin
      cmd_q   <= request.cmd;
      row_q   <= request.row;
      col_q   <= request.col;
      value_q <= request.value;
    end
    if (ctrl.adv_step) begin
      up_row  <= mid_row;
      mid_row <= ram_rdata;
      if (step == STEP_FIRST) begin
        first_row <= ram_rdata;
      end
    end
    if (ctrl.res_clear) begin
      res_cell <= 1'b0;
      res_gen  <= 1'b0;
    end
    if (ctrl.cell_capture) begin
      res_cell <= ram_rdata[col_idx];
    end
    if (ctrl.gen_set) begin
      res_gen <= 1'b1;
    end
    if (ctrl.out_load) begin
      out_cell <= res_cell;
      out_gen  <= res_gen;
    end
  end

  assign response.valid           = out_valid;
  assign response.cell_value      = out_cell;
  assign response.generation_done = out_gen;

  assign stat.op         = cmd_q;
  assign stat.item_taken = item_taken;
  assign stat.in_grid    = in_grid;
  assign stat.run_en     = run_enable;
  assign stat.clear_last = (step == CLEAR_LAST);
  assign stat.adv_last   = (step == ADV_LAST);
  assign stat.out_free   = !out_valid || response.ready;

endmodule

// ===== rtl/tla_checker.sv =====
module tla_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_cell_value,
  input logic rsp_generation_done
);

  a_reset_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready during the clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second item taken while one is at work");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_cell_value && rsp_generation_done))
    else $error("result shows a cell value and a generation at once");

  a_rsp_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result item dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> ($stable(rsp_cell_value) && $stable(rsp_generation_done)))
    else $error("stalled result item changed");

endmodule

bind toroidal_life_automaton_unit tla_checker u_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (request.valid),
  .req_ready          (request.ready),
  .rsp_valid          (response.valid),
  .rsp_ready          (response.ready),
  .rsp_cell_value     (response.cell_value),
  .rsp_generation_done(response.generation_done)
);

// ===== tb/toroidal_life_automaton_unit_tb.sv =====
module toroidal_life_automaton_unit_tb;
  import tla_pkg::*;

  localparam int GRID_R = 64;
  localparam int GRID_C = 64;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CLK_PERIOD = 10;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BURSTS = 9;
  localparam int BURST_ITEMS = 48;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic       value;
  } grid_cmd_t;

  typedef struct packed {
    logic cell_value;
    logic generation_done;
  } grid_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  tla_req_if req_if();
  tla_rsp_if rsp_if();

  toroidal_life_automaton_unit #(
    .GRID_ROWS(GRID_R),
    .GRID_COLS(GRID_C)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .request(req_if),
    .response(rsp_if),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  bit [GRID_C-1:0] life_grid [GRID_R];
  bit [GRID_C-1:0] next_grid [GRID_R];
  bit run_enable_q;

  grid_cmd_t grid_cmds[$];
  grid_rsp_t cell_answers[$];
  grid_cmd_t cur_cmd;
  bit offering;
  int tx_left;
  int rx_left;
  bit tx_gapless;
  bit rx_gapless;
  bit hold_armed;
  int n_issued;
  int n_taken;
  int n_checked;
  int n_errors;
  int n_reads;
  int n_writes;
  int n_generations;
  int idle_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit cell_at(int r, int c);
    return life_grid[(r + GRID_R) % GRID_R][(c + GRID_C) % GRID_C];
  endfunction

  function automatic grid_rsp_t grid_step(grid_cmd_t it);
    grid_rsp_t res;
    int nb;
    bit alive;
    res = '0;
    case (it.cmd)
      CMD_WRITE: begin
        if (it.row < GRID_R && it.col < GRID_C) life_grid[it.row][it.col] = it.value;
        n_writes++;
      end
      CMD_READ: begin
        if (it.row < GRID_R && it.col < GRID_C) res.cell_value = life_grid[it.row][it.col];
        n_reads++;
      end
      CMD_ADVANCE: begin
        if (run_enable_q) begin
          for (int rr = 0; rr < GRID_R; rr++) begin
            for (int cc = 0; cc < GRID_C; cc++) begin
              nb = 0;
              for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) nb += cell_at(rr + dr, cc + dc);
                end
              end
              alive = life_grid[rr][cc];
              next_grid[rr][cc] = (nb == 3) || (alive && nb == 2);
            end
          end
          life_grid = next_grid;
          res.generation_done = 1'b1;
          n_generations++;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void add_cmd(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                                  logic value);
    grid_cmd_t it;
    it.cmd = cmd;
    it.row = row;
    it.col = col;
    it.value = value;
    grid_cmds.push_back(it);
  endfunction

  // Most items land in a small window so that written patterns evolve and get read back.
  function automatic void add_random_burst(int count);
    logic [5:0] cr;
    logic [5:0] cc;
    logic [5:0] r6;
    logic [5:0] c6;
    int roll;
    cr = 6'($urandom);
    cc = 6'($urandom);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      r6 = cr + 6'($urandom_range(0, 7));
      c6 = cc + 6'($urandom_range(0, 7));
      if (roll < 4) begin
        add_cmd(CMD_SPARE, 6'($urandom), 6'($urandom), 1'($urandom));
      end else if (roll < 18) begin
        add_cmd(CMD_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom));
      end else if (roll < 50) begin
        add_cmd(CMD_WRITE, r6, c6, $urandom_range(0, 99) < 45);
      end else if (roll < 88) begin
        add_cmd(CMD_READ, r6, c6, 1'($urandom));
      end else if (roll < 94) begin
        add_cmd(CMD_WRITE, 6'($urandom), 6'($urandom), 1'($urandom));
      end else begin
        add_cmd(CMD_READ, 6'($urandom), 6'($urandom), 1'($urandom));
      end
    end
  endfunction

  task automatic wait_idle();
    while (grid_cmds.size() != 0 || n_taken != n_issued || cell_answers.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_run(bit on);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= on;
    @(posedge clk);
    cfg_write <= 1'b0;
    run_enable_q = on;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      offering = 1'b0;
      tx_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        cell_answers.push_back(grid_step(cur_cmd));
        n_taken++;
        offering = 1'b0;
        tx_left = tx_gapless ? 0 : $urandom_range(0, 12);
      end
      if (!offering) begin
        if (tx_left > 0) begin
          tx_left--;
          req_if.valid <= 1'b0;
        end else if (grid_cmds.size() > 0) begin
          cur_cmd = grid_cmds.pop_front();
          req_if.valid <= 1'b1;
          req_if.cmd <= cur_cmd.cmd;
          req_if.row <= cur_cmd.row;
          req_if.col <= cur_cmd.col;
          req_if.value <= cur_cmd.value;
          offering = 1'b1;
          n_issued++;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    grid_rsp_t want;
    int wait_n;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      rx_left = 0;
    end else begin
      wait_n = rx_left;
      if (rsp_if.valid && rsp_if.ready) begin
        if (cell_answers.size() == 0) begin
          $display("%0t: unexpected item, cell_value %0b generation_done %0b", $time,
                   rsp_if.cell_value, rsp_if.generation_done);
          n_errors++;
        end else begin
          want = cell_answers.pop_front();
          n_checked++;
          if (rsp_if.cell_value !== want.cell_value) begin
            $display("%0t: cell_value mismatch, expected %0b, got %0b", $time,
                     want.cell_value, rsp_if.cell_value);
            n_errors++;
          end
          if (rsp_if.generation_done !== want.generation_done) begin
            $display("%0t: generation_done mismatch, expected %0b, got %0b", $time,
                     want.generation_done, rsp_if.generation_done);
            n_errors++;
          end
        end
        wait_n = rx_gapless ? 0 : $urandom_range(0, 12);
      end
      if (hold_armed) begin
        wait_n = LONG_HOLD;
        hold_armed = 1'b0;
      end
      if (wait_n > 0) begin
        rsp_if.ready <= 1'b0;
        rx_left = wait_n - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        rx_left = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_WRITE;
    req_if.row = '0;
    req_if.col = '0;
    req_if.value = 1'b0;
    rsp_if.ready = 1'b0;
    idle_cycles = 0;
    tx_gapless = 1'b0;
    rx_gapless = 1'b0;
    hold_armed = 1'b0;
    run_enable_q = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_run(1'b0);
    add_cmd(CMD_READ, 0, 0, 0);
    add_cmd(CMD_SPARE, 63, 63, 1);
    add_cmd(CMD_ADVANCE, 63, 63, 1);
    add_cmd(CMD_WRITE, 63, 63, 1);
    add_cmd(CMD_READ, 63, 63, 0);
    add_cmd(CMD_WRITE, 0, 0, 1);
    add_cmd(CMD_ADVANCE, 0, 0, 0);
    add_cmd(CMD_READ, 0, 0, 1);
    add_cmd(CMD_WRITE, 63, 63, 0);
    add_cmd(CMD_WRITE, 0, 0, 0);
    add_cmd(CMD_READ, 63, 63, 1);
    wait_idle();

    // A blinker laid across the column wrap flips to a column across the row wrap.
    set_run(1'b1);
    add_cmd(CMD_WRITE, 0, 63, 1);
    add_cmd(CMD_WRITE, 0, 0, 1);
    add_cmd(CMD_WRITE, 0, 1, 1);
    add_cmd(CMD_ADVANCE, 0, 0, 0);
    add_cmd(CMD_READ, 63, 0, 0);
    add_cmd(CMD_READ, 0, 0, 0);
    add_cmd(CMD_READ, 1, 0, 0);
    add_cmd(CMD_READ, 0, 63, 0);
    add_cmd(CMD_ADVANCE, 63, 63, 1);
    add_cmd(CMD_READ, 0, 63, 0);
    add_cmd(CMD_READ, 0, 1, 0);
    wait_idle();

    for (int p = 0; p < RANDOM_BURSTS; p++) begin
      set_run(p % 3 != 2);
      tx_gapless = (p % 4 == 1) || (p == 4);
      rx_gapless = (p % 4 == 3);
      if (p == 4) hold_armed = 1'b1;
      add_random_burst(BURST_ITEMS);
      wait_idle();
    end

    repeat (GRID_R + 10) @(posedge clk);
    $display("Sent %0d items: %0d writes, %0d reads, %0d generations computed.",
             n_taken, n_writes, n_reads, n_generations);
    $display("Compared %0d results and found %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== toroidal_life_automaton_unit.f =====
rtl/tla_pkg.sv
rtl/tla_req_if.sv
rtl/tla_rsp_if.sv
rtl/tla_ram.sv
rtl/tla_ctrl.sv
rtl/tla_datapath.sv
rtl/toroidal_life_automaton_unit.sv
rtl/tla_checker.sv
tb/toroidal_life_automaton_unit_tb.sv
